FILE: rtl/jtag_tap_shift_sequencer_core_defines.svh
// Assertion macros shared by the JTAG TAP shift sequencer checker.
// No dependencies; pulled in by the checker file.
`ifndef JTAG_TAP_SHIFT_SEQUENCER_CORE_DEFINES_SVH
`define JTAG_TAP_SHIFT_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define JTSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define JTSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/jtss_pkg.sv
// Types, codes and helper functions of the JTAG TAP shift sequencer.
// No dependencies; imported by the step logic, the top level and the checker.
package jtss_pkg;

  localparam int DATA_WIDTH      = 32;
  localparam int MAX_BYPASS_BITS = 63;
  localparam int CNT_W           = 6;
  localparam int RESET_CLOCKS    = 7;
  localparam int IN_W            = 48;
  localparam int OUT_W           = 40;

  // TAP state codes
  localparam logic [3:0] TAP_UNKNOWN = 4'd0;
  localparam logic [3:0] TAP_RESET   = 4'd1;
  localparam logic [3:0] TAP_IDLE    = 4'd2;
  localparam logic [3:0] TAP_SEL_DR  = 4'd3;
  localparam logic [3:0] TAP_SEL_IR  = 4'd4;
  localparam logic [3:0] TAP_CAPTURE = 4'd5;
  localparam logic [3:0] TAP_SHIFT   = 4'd6;
  localparam logic [3:0] TAP_EXIT1   = 4'd7;
  localparam logic [3:0] TAP_PAUSE   = 4'd8;
  localparam logic [3:0] TAP_EXIT2   = 4'd9;
  localparam logic [3:0] TAP_UPDATE  = 4'd10;

  // operation codes
  localparam logic [2:0] OP_RESET    = 3'd0;
  localparam logic [2:0] OP_IDLE     = 3'd1;
  localparam logic [2:0] OP_SEL_DR   = 3'd2;
  localparam logic [2:0] OP_SEL_IR   = 3'd3;
  localparam logic [2:0] OP_SHIFT_IR = 3'd4;
  localparam logic [2:0] OP_SHIFT_DR = 3'd5;
  localparam logic [2:0] OP_UPD_IDLE = 3'd6;

  // sequencer phases
  localparam logic [2:0] PH_NAV   = 3'd0;
  localparam logic [2:0] PH_RST   = 3'd1;
  localparam logic [2:0] PH_ENTER = 3'd2;
  localparam logic [2:0] PH_HEAD  = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_TRAIL = 3'd5;
  localparam logic [2:0] PH_UPD   = 3'd6;

  // beat kinds on s_tuser
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_IR_LENGTH   = 3'd0;
  localparam logic [2:0] CFG_IR_HEADER   = 3'd1;
  localparam logic [2:0] CFG_IR_TRAILER  = 3'd2;
  localparam logic [2:0] CFG_DR_HEADER   = 3'd3;
  localparam logic [2:0] CFG_DR_TRAILER  = 3'd4;

  typedef struct packed {
    logic [CNT_W-1:0] ir_length;
    logic [CNT_W-1:0] ir_header;
    logic [CNT_W-1:0] ir_trailer;
    logic [CNT_W-1:0] dr_header;
    logic [CNT_W-1:0] dr_trailer;
  } jtss_cfg_t;

  typedef struct packed {
    logic [3:0]            tap;
    logic [2:0]            op;
    logic                  busy;
    logic [2:0]            phase;
    logic [CNT_W-1:0]      cnt;
    logic [CNT_W-1:0]      len;
    logic [DATA_WIDTH-1:0] sr;
  } jtss_state_t;

  typedef struct packed {
    logic                  ce;
    logic                  tms;
    logic                  tdi;
    logic                  done;
    logic [DATA_WIDTH-1:0] captured;
    logic [3:0]            tap;
  } jtss_tick_t;

  function automatic logic [3:0] tap_next(input logic [3:0] s, input logic tms);
    logic [3:0] n;
    unique case (s)
      TAP_RESET:               n = tms ? TAP_RESET  : TAP_IDLE;
      TAP_IDLE:                n = tms ? TAP_SEL_DR : TAP_IDLE;
      TAP_SEL_DR:              n = tms ? TAP_SEL_IR : TAP_CAPTURE;
      TAP_SEL_IR:              n = tms ? TAP_RESET  : TAP_CAPTURE;
      TAP_CAPTURE, TAP_SHIFT:  n = tms ? TAP_EXIT1  : TAP_SHIFT;
      TAP_EXIT1:               n = tms ? TAP_UPDATE : TAP_PAUSE;
      TAP_PAUSE:               n = tms ? TAP_EXIT2  : TAP_PAUSE;
      TAP_EXIT2:               n = tms ? TAP_UPDATE : TAP_SHIFT;
      TAP_UPDATE:              n = tms ? TAP_SEL_DR : TAP_IDLE;
      default:                 n = TAP_UNKNOWN;
    endcase
    return n;
  endfunction

  function automatic logic at_target(input logic [2:0] op, input logic [3:0] s);
    logic r;
    if (op == OP_SEL_DR || op == OP_SHIFT_DR) begin
      r = (s == TAP_SEL_DR);
    end else if (op == OP_SEL_IR || op == OP_SHIFT_IR) begin
      r = (s == TAP_SEL_IR);
    end else begin
      r = (s == TAP_UPDATE) || (s == TAP_IDLE);
    end
    return r;
  endfunction

  // TMS level that walks one step toward the operation's target
  function automatic logic nav_tms(input logic [2:0] op, input logic [3:0] s);
    logic r;
    if (op == OP_IDLE) begin
      r = (s >= TAP_CAPTURE) && (s <= TAP_EXIT2);
    end else if (op == OP_UPD_IDLE) begin
      r = (s != TAP_RESET);
    end else begin
      r = !((s == TAP_RESET) || (s == TAP_SEL_IR));
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] clamp_len(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] r;
    if (n == '0) begin
      r = CNT_W'(1);
    end else if (n > CNT_W'(DATA_WIDTH)) begin
      r = CNT_W'(DATA_WIDTH);
    end else begin
      r = n;
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] clamp_bypass(input logic [CNT_W-1:0] n);
    logic [CNT_W:0] lim;
    lim = (CNT_W+1)'(MAX_BYPASS_BITS);
    return ({1'b0, n} > lim) ? lim[CNT_W-1:0] : n;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] low_mask(input logic [CNT_W-1:0] n);
    logic [DATA_WIDTH-1:0] m;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      m[i] = (i < int'(n));
    end
    return m;
  endfunction

endpackage

FILE: rtl/jtag_tap_shift_sequencer_core.sv
// JTAG TAP shift sequencer: input beat register, one-beat step logic, result register.
// Depends on jtss_pkg and jtss_step.
//
// Takes one beat per clock unless a held result stalls it. A start beat (s_tuser low)
// loads an operation and gives no result; each tick beat (s_tuser high) runs one TCK
// step of the current operation and gives exactly one result beat, presented through
// the input register and then the result register, with m_tlast marking the last tick
// of the operation. A result beat held by m_tready low holds a waiting tick in the
// input register, so s_tready stays low until the result is taken.
// The TAP model, phase and bit counter are updated in the same cycle as the step
// logic, so ticks follow each other without gaps. Configuration writes are
// dropped while an operation is in progress.
module jtag_tap_shift_sequencer_core
  import jtss_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // configuration write port
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CNT_W-1:0] cfg_data,
  // command stream
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // operation, shift_value, dr_length, tdo_sample
  input  logic             s_tuser,   // cmd: start or tick
  // tick result stream
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // clock_enable, tms_out, tdi_out, captured_value,
                                      // tap_state_out, zero pad
  output logic             m_tlast    // op_done
);

  jtss_cfg_t   cfg;
  jtss_state_t st;
  jtss_state_t st_next;
  jtss_tick_t  res;

  logic                  in_valid;
  logic                  in_cmd;
  logic [2:0]            in_op;
  logic [DATA_WIDTH-1:0] in_value;
  logic [CNT_W-1:0]      in_len;
  logic                  in_tdo;
  logic                  in_start;
  logic                  advance;

  assign in_start = (in_cmd == CMD_START);
  assign advance  = in_valid && (in_start || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ir_length  <= CNT_W'(6);
      cfg.ir_header  <= '0;
      cfg.ir_trailer <= '0;
      cfg.dr_header  <= '0;
      cfg.dr_trailer <= '0;
    end else if (cfg_we && !st.busy) begin
      unique case (cfg_index)
        CFG_IR_LENGTH:  cfg.ir_length  <= cfg_data;
        CFG_IR_HEADER:  cfg.ir_header  <= cfg_data;
        CFG_IR_TRAILER: cfg.ir_trailer <= cfg_data;
        CFG_DR_HEADER:  cfg.dr_header  <= cfg_data;
        CFG_DR_TRAILER: cfg.dr_trailer <= cfg_data;
        default: ;
      endcase
    end
  end

  // input beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd   <= s_tuser;
      in_op    <= s_tdata[2:0];
      in_value <= s_tdata[34:3];
      in_len   <= s_tdata[40:35];
      in_tdo   <= s_tdata[41];
    end
  end

  jtss_step u_step (
    .st          (st),
    .cfg         (cfg),
    .start       (in_start),
    .op_in       (in_op),
    .shift_value (in_value),
    .dr_length   (in_len),
    .tdo         (in_tdo),
    .st_next     (st_next),
    .res         (res)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && !in_start) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !in_start) begin
      m_tdata <= {1'b0, res.tap, res.captured, res.tdi, res.tms, res.ce};
      m_tlast <= res.done;
    end
  end

endmodule

FILE: rtl/jtss_step.sv
// One beat of the JTAG sequencer: start or TCK tick, from current state to next state.
// Depends on jtss_pkg for types, codes and TAP helper functions.
module jtss_step
  import jtss_pkg::*;
(
  input  jtss_state_t              st,
  input  jtss_cfg_t                cfg,
  input  logic                     start,
  input  logic [2:0]               op_in,
  input  logic [DATA_WIDTH-1:0]    shift_value,
  input  logic [CNT_W-1:0]         dr_length,
  input  logic                     tdo,
  output jtss_state_t              st_next,
  output jtss_tick_t               res
);

  logic             is_shift;
  logic             nav_hold;
  logic [2:0]       ph;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W:0]   cnt_inc;
  logic [CNT_W-1:0] hdr;
  logic [CNT_W-1:0] trl;
  logic [CNT_W-1:0] slen;
  logic [3:0]       tap;
  logic             clk_e;
  logic             tms;
  logic             tdi;
  logic             done;
  logic [DATA_WIDTH-1:0] captured;
  logic [DATA_WIDTH-1:0] sr;
  logic [$clog2(DATA_WIDTH)-1:0] top_idx;

  always_comb begin
    st_next  = st;
    is_shift = (st.op == OP_SHIFT_IR) || (st.op == OP_SHIFT_DR);
    hdr      = clamp_bypass(st.op == OP_SHIFT_IR ? cfg.ir_header  : cfg.dr_header);
    trl      = clamp_bypass(st.op == OP_SHIFT_IR ? cfg.ir_trailer : cfg.dr_trailer);
    nav_hold = 1'b0;
    ph       = st.phase;
    cnt      = st.cnt;
    tap      = st.tap;
    sr       = st.sr;
    clk_e    = 1'b0;
    tms      = 1'b0;
    tdi      = 1'b0;
    done     = 1'b0;
    captured = '0;
    cnt_inc  = {1'b0, st.cnt} + 1'b1;
    slen     = clamp_len(op_in == OP_SHIFT_IR ? cfg.ir_length : dr_length);
    top_idx  = $clog2(DATA_WIDTH)'(st.len - 1'b1);

    if (start) begin
      // load a new operation when free
      if (!st.busy && op_in <= OP_UPD_IDLE) begin
        st_next.op    = op_in;
        st_next.busy  = 1'b1;
        st_next.phase = PH_NAV;
        st_next.cnt   = '0;
        st_next.len   = slen;
        st_next.sr    = shift_value & low_mask(slen);
      end
    end else if (st.busy) begin
      if (ph > PH_UPD) begin
        ph = PH_NAV;
      end

      // resolve phases that pass through without a clock
      if (ph == PH_NAV) begin
        if (st.op == OP_RESET || tap == TAP_UNKNOWN || tap > TAP_UPDATE) begin
          ph  = PH_RST;
          cnt = '0;
        end else if (st.op != OP_IDLE && at_target(st.op, tap)) begin
          if (is_shift) begin
            ph  = PH_ENTER;
            cnt = '0;
          end else begin
            nav_hold = 1'b1;
          end
        end
      end
      if (ph == PH_HEAD && cnt >= hdr) begin
        ph  = PH_DATA;
        cnt = '0;
      end
      if (ph == PH_DATA && cnt >= st.len) begin
        ph  = PH_TRAIL;
        cnt = '0;
      end
      if (ph == PH_TRAIL && cnt >= trl) begin
        ph  = PH_UPD;
        cnt = '0;
      end
      cnt_inc = {1'b0, cnt} + 1'b1;

      // the clocked action of the resolved phase
      unique case (ph)
        PH_NAV: begin
          if (nav_hold) begin
            done = 1'b1;
          end else begin
            clk_e = 1'b1;
            tms   = nav_tms(st.op, tap);
            tap   = tap_next(tap, tms);
            if (st.op == OP_IDLE) begin
              done = (tap == TAP_IDLE);
            end else begin
              done = !is_shift && at_target(st.op, tap);
            end
          end
        end
        PH_RST: begin
          clk_e = 1'b1;
          tms   = 1'b1;
          tdi   = 1'b1;
          cnt   = cnt_inc[CNT_W-1:0];
          if (cnt_inc >= (CNT_W+1)'(RESET_CLOCKS)) begin
            tap = TAP_RESET;
            cnt = '0;
            if (st.op == OP_RESET) begin
              done = 1'b1;
            end else begin
              ph = PH_NAV;
            end
          end
        end
        PH_ENTER: begin
          clk_e = 1'b1;
          tap   = tap_next(tap, 1'b0);
          cnt   = cnt_inc[CNT_W-1:0];
          if (cnt_inc >= (CNT_W+1)'(2)) begin
            ph  = PH_HEAD;
            cnt = '0;
          end
        end
        PH_HEAD: begin
          clk_e = 1'b1;
          tdi   = 1'b1;
          tap   = tap_next(tap, 1'b0);
          cnt   = cnt_inc[CNT_W-1:0];
        end
        PH_DATA: begin
          // shift out LSB, rotate TDO in at the top of the active length
          clk_e = 1'b1;
          tms   = (cnt_inc >= {1'b0, st.len}) && (trl == '0);
          tdi   = st.sr[0];
          sr    = (st.sr >> 1) | (DATA_WIDTH'(tdo) << top_idx);
          tap   = tap_next(tap, tms);
          cnt   = cnt_inc[CNT_W-1:0];
          if (cnt_inc >= {1'b0, st.len}) begin
            ph  = PH_TRAIL;
            cnt = '0;
          end
        end
        PH_TRAIL: begin
          clk_e = 1'b1;
          tdi   = 1'b1;
          tms   = (cnt_inc >= {1'b0, trl});
          tap   = tap_next(tap, tms);
          cnt   = cnt_inc[CNT_W-1:0];
        end
        PH_UPD: begin
          clk_e    = 1'b1;
          tms      = 1'b1;
          tdi      = 1'b1;
          tap      = tap_next(tap, 1'b1);
          done     = 1'b1;
          captured = st.sr & low_mask(st.len);
        end
        default: begin
          ph = PH_NAV;
        end
      endcase

      st_next.tap   = tap;
      st_next.sr    = sr;
      st_next.phase = ph;
      st_next.cnt   = cnt;
      if (done) begin
        st_next.busy  = 1'b0;
        st_next.phase = PH_NAV;
        st_next.cnt   = '0;
      end
    end

    res.ce       = clk_e;
    res.tms      = tms;
    res.tdi      = tdi;
    res.done     = done;
    res.captured = captured;
    res.tap      = tap;
  end

endmodule

FILE: rtl/jtss_checker.sv
// Port-level checker for the JTAG TAP shift sequencer, bound to the top level.
// Depends on jtss_pkg and jtag_tap_shift_sequencer_core_defines.svh.
`include "jtag_tap_shift_sequencer_core_defines.svh"

module jtss_checker
  import jtss_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast
);

  logic [3:0] out_tap;
  assign out_tap = m_tdata[38:35];

  // stalled result beat holds
  `JTSS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result beat changed while stalled")

  // pins are quiet on a tick without TCK
  `JTSS_ASSERT_NOW(a_quiet_pins, clk, rst, m_tvalid && !m_tdata[0], !m_tdata[1] && !m_tdata[2], "TMS or TDI driven without a clock")

  // captured data only on the last tick
  `JTSS_ASSERT_NOW(a_capture_last, clk, rst, m_tvalid && !m_tlast, m_tdata[34:3] == '0, "captured data outside op_done")

  // an operation ending without a clock is already at a target state
  `JTSS_ASSERT_NOW(a_done_target, clk, rst, m_tvalid && m_tlast && !m_tdata[0], out_tap == TAP_UPDATE || out_tap == TAP_IDLE || out_tap == TAP_SEL_DR || out_tap == TAP_SEL_IR, "unclocked done away from a target state")

endmodule

bind jtag_tap_shift_sequencer_core jtss_checker u_jtss_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

FILE: tb/jtss_tick_checker.sv
// Result checker for the JTAG TAP shift sequencer: predicts each tick beat and compares.
// Depends on jtss_pkg; instantiated beside the block by tb_jtag_tap_shift_sequencer_core.
module jtss_tick_checker
  import jtss_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // operation, shift_value, dr_length, tdo_sample
  input  logic             s_tuser,   // cmd
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,   // clock_enable, tms_out, tdi_out, captured_value,
                                      // tap_state_out, zero pad
  input  logic             m_tlast,   // op_done
  output int               fail_count,
  output int               pending,
  output logic             busy_now
);

  typedef struct {
    logic                  ce;
    logic                  tms;
    logic                  tdi;
    logic                  done;
    logic [DATA_WIDTH-1:0] captured;
    logic [3:0]            tap;
  } tick_expect_t;

  tick_expect_t tick_q[$];
  tick_expect_t head;

  // register copies
  logic [CNT_W-1:0] ir_len_r, ir_hdr_r, ir_trl_r, dr_hdr_r, dr_trl_r;

  // sequencer model
  logic [3:0]            tap_m;
  logic [2:0]            op_m;
  logic                  busy_m;
  logic [2:0]            phase_m;
  int                    cnt_m;
  int                    len_m;
  logic [DATA_WIDTH-1:0] sr_m;
  int                    errs = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
    busy_now   = 1'b0;
  end

  // one TCK step of the TAP graph
  function automatic logic [3:0] tap_after(input logic [3:0] s, input logic tms);
    case (s)
      TAP_RESET:              return tms ? TAP_RESET  : TAP_IDLE;
      TAP_IDLE:               return tms ? TAP_SEL_DR : TAP_IDLE;
      TAP_SEL_DR:             return tms ? TAP_SEL_IR : TAP_CAPTURE;
      TAP_SEL_IR:             return tms ? TAP_RESET  : TAP_CAPTURE;
      TAP_CAPTURE, TAP_SHIFT: return tms ? TAP_EXIT1  : TAP_SHIFT;
      TAP_EXIT1:              return tms ? TAP_UPDATE : TAP_PAUSE;
      TAP_PAUSE:              return tms ? TAP_EXIT2  : TAP_PAUSE;
      TAP_EXIT2:              return tms ? TAP_UPDATE : TAP_SHIFT;
      TAP_UPDATE:             return tms ? TAP_SEL_DR : TAP_IDLE;
      default:                return TAP_UNKNOWN;
    endcase
  endfunction

  function automatic logic reached(input logic [2:0] op, input logic [3:0] s);
    if (op == OP_SEL_DR || op == OP_SHIFT_DR) return s == TAP_SEL_DR;
    if (op == OP_SEL_IR || op == OP_SHIFT_IR) return s == TAP_SEL_IR;
    return (s == TAP_UPDATE) || (s == TAP_IDLE);
  endfunction

  // TMS that moves one step toward the target of op
  function automatic logic toward(input logic [2:0] op, input logic [3:0] s);
    if (op == OP_IDLE) return (s >= TAP_CAPTURE) && (s <= TAP_EXIT2);
    if (op == OP_UPD_IDLE) return s != TAP_RESET;
    return !((s == TAP_RESET) || (s == TAP_SEL_IR));
  endfunction

  function automatic logic [DATA_WIDTH-1:0] ones_below(input int n);
    logic [DATA_WIDTH:0] one;
    one = 1;
    return DATA_WIDTH'((one << n) - 1);
  endfunction

  function automatic int bypass_limit(input logic [CNT_W-1:0] n);
    return (int'(n) > MAX_BYPASS_BITS) ? MAX_BYPASS_BITS : int'(n);
  endfunction

  function automatic void check_field(input string name, input logic [DATA_WIDTH-1:0] want,
                                      input logic [DATA_WIDTH-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      errs++;
    end
  endfunction

  // apply one accepted input beat to the model; a tick queues its expected result
  task automatic predict_beat(input logic kind, input logic [IN_W-1:0] d);
    logic [2:0]            op;
    logic [DATA_WIDTH-1:0] val;
    logic [CNT_W-1:0]      dlen;
    logic [CNT_W-1:0]      want_len;
    logic                  tdo;
    logic                  ce, tms, tdi, done;
    logic [DATA_WIDTH-1:0] cap;
    bit                    shifting, again;
    int                    hdr, trl, lap;
    tick_expect_t          t;
    op   = d[2:0];
    val  = d[34:3];
    dlen = d[40:35];
    tdo  = d[41];

    if (kind == CMD_START) begin
      if (!busy_m && op <= OP_UPD_IDLE) begin
        op_m     = op;
        busy_m   = 1'b1;
        phase_m  = PH_NAV;
        cnt_m    = 0;
        want_len = (op == OP_SHIFT_IR) ? ir_len_r : dlen;
        if (want_len == 0) len_m = 1;
        else if (int'(want_len) > DATA_WIDTH) len_m = DATA_WIDTH;
        else len_m = int'(want_len);
        sr_m = val & ones_below(len_m);
      end
      return;
    end

    ce   = 1'b0;
    tms  = 1'b0;
    tdi  = 1'b1;
    done = 1'b0;
    cap  = '0;
    if (!busy_m) begin
      tdi = 1'b0;
    end else begin
      shifting = (op_m == OP_SHIFT_IR) || (op_m == OP_SHIFT_DR);
      hdr = bypass_limit(op_m == OP_SHIFT_IR ? ir_hdr_r : dr_hdr_r);
      trl = bypass_limit(op_m == OP_SHIFT_IR ? ir_trl_r : dr_trl_r);
      again = 1'b1;
      for (lap = 0; again && lap < 8; lap++) begin
        again = 1'b0;
        case (phase_m)
          PH_NAV: begin
            if (op_m == OP_RESET || tap_m == TAP_UNKNOWN || tap_m > TAP_UPDATE) begin
              phase_m = PH_RST;
              cnt_m   = 0;
              again   = 1'b1;
            end else if (op_m == OP_IDLE) begin
              ce    = 1'b1;
              tdi   = 1'b0;
              tms   = toward(op_m, tap_m);
              tap_m = tap_after(tap_m, tms);
              if (tap_m == TAP_IDLE) done = 1'b1;
            end else if (reached(op_m, tap_m)) begin
              if (shifting) begin
                phase_m = PH_ENTER;
                cnt_m   = 0;
                again   = 1'b1;
              end else begin
                tdi  = 1'b0;
                done = 1'b1;
              end
            end else begin
              ce    = 1'b1;
              tdi   = 1'b0;
              tms   = toward(op_m, tap_m);
              tap_m = tap_after(tap_m, tms);
              if (!shifting && reached(op_m, tap_m)) done = 1'b1;
            end
          end
          PH_RST: begin
            ce  = 1'b1;
            tms = 1'b1;
            tdi = 1'b1;
            cnt_m++;
            if (cnt_m >= RESET_CLOCKS) begin
              tap_m = TAP_RESET;
              cnt_m = 0;
              if (op_m == OP_RESET) done = 1'b1;
              else phase_m = PH_NAV;
            end
          end
          PH_ENTER: begin
            // select -> capture -> shift
            ce    = 1'b1;
            tms   = 1'b0;
            tdi   = 1'b0;
            tap_m = tap_after(tap_m, 1'b0);
            cnt_m++;
            if (cnt_m >= 2) begin
              phase_m = PH_HEAD;
              cnt_m   = 0;
            end
          end
          PH_HEAD: begin
            if (cnt_m >= hdr) begin
              phase_m = PH_DATA;
              cnt_m   = 0;
              again   = 1'b1;
            end else begin
              ce    = 1'b1;
              tms   = 1'b0;
              tdi   = 1'b1;
              tap_m = tap_after(tap_m, 1'b0);
              cnt_m++;
            end
          end
          PH_DATA: begin
            if (cnt_m >= len_m) begin
              phase_m = PH_TRAIL;
              cnt_m   = 0;
              again   = 1'b1;
            end else begin
              // LSB out on TDI, TDO rotated in at the top of the active length
              ce    = 1'b1;
              tms   = (cnt_m + 1 >= len_m) && (trl == 0);
              tdi   = sr_m[0];
              sr_m  = ((sr_m >> 1) | (DATA_WIDTH'(tdo) << (len_m - 1))) & ones_below(len_m);
              tap_m = tap_after(tap_m, tms);
              cnt_m++;
              if (cnt_m >= len_m) begin
                phase_m = PH_TRAIL;
                cnt_m   = 0;
              end
            end
          end
          PH_TRAIL: begin
            if (cnt_m >= trl) begin
              phase_m = PH_UPD;
              cnt_m   = 0;
              again   = 1'b1;
            end else begin
              ce    = 1'b1;
              tdi   = 1'b1;
              tms   = (cnt_m + 1 >= trl);
              tap_m = tap_after(tap_m, tms);
              cnt_m++;
            end
          end
          PH_UPD: begin
            ce    = 1'b1;
            tms   = 1'b1;
            tdi   = 1'b1;
            tap_m = tap_after(tap_m, 1'b1);
            done  = 1'b1;
            cap   = sr_m & ones_below(len_m);
          end
          default: begin
            phase_m = PH_NAV;
            again   = 1'b1;
          end
        endcase
      end
      // no pulse means pins parked low
      if (!ce) begin
        tms = 1'b0;
        if (!done) tdi = 1'b0;
      end
      if (!ce && done) tdi = 1'b0;
      if (done) begin
        busy_m  = 1'b0;
        phase_m = PH_NAV;
        cnt_m   = 0;
      end
    end

    t.ce       = ce;
    t.tms      = tms;
    t.tdi      = tdi;
    t.done     = done;
    t.captured = cap;
    t.tap      = tap_m;
    tick_q.push_back(t);
  endtask

  // sample both channels and the register port at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      ir_len_r = CNT_W'(6);
      ir_hdr_r = '0;
      ir_trl_r = '0;
      dr_hdr_r = '0;
      dr_trl_r = '0;
      tap_m    = TAP_UNKNOWN;
      op_m     = OP_RESET;
      busy_m   = 1'b0;
      phase_m  = PH_NAV;
      cnt_m    = 0;
      len_m    = 0;
      sr_m     = '0;
      tick_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (tick_q.size() == 0) begin
          $error("result beat with no tick waiting: tdata 0x%0h", m_tdata);
          errs++;
        end else begin
          head = tick_q.pop_front();
          check_field("clock_enable", DATA_WIDTH'(head.ce), DATA_WIDTH'(m_tdata[0]));
          check_field("tms_out", DATA_WIDTH'(head.tms), DATA_WIDTH'(m_tdata[1]));
          check_field("tdi_out", DATA_WIDTH'(head.tdi), DATA_WIDTH'(m_tdata[2]));
          check_field("op_done", DATA_WIDTH'(head.done), DATA_WIDTH'(m_tlast));
          check_field("captured_value", head.captured, m_tdata[34:3]);
          check_field("tap_state_out", DATA_WIDTH'(head.tap), DATA_WIDTH'(m_tdata[38:35]));
        end
      end
      if (cfg_we && !busy_m) begin
        case (cfg_index)
          CFG_IR_LENGTH:  ir_len_r = cfg_data;
          CFG_IR_HEADER:  ir_hdr_r = cfg_data;
          CFG_IR_TRAILER: ir_trl_r = cfg_data;
          CFG_DR_HEADER:  dr_hdr_r = cfg_data;
          CFG_DR_TRAILER: dr_trl_r = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_beat(s_tuser, s_tdata);
    end
    fail_count <= errs;
    pending    <= tick_q.size();
    busy_now   <= busy_m;
  end

endmodule

FILE: tb/tb_jtag_tap_shift_sequencer_core.sv
// Top of the JTAG TAP shift sequencer testbench: clock, reset, stimulus and verdict.
// Depends on jtss_pkg, jtag_tap_shift_sequencer_core and jtss_tick_checker.
module tb_jtag_tap_shift_sequencer_core;
  import jtss_pkg::*;

  localparam logic [2:0] CFG_NO_REG        = 3'd7;
  localparam logic [2:0] OP_UNUSED         = 3'd7;
  localparam int         BEATS_PER_SETTING = 85;
  localparam int         SETTINGS_PER_MODE = 4;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [2:0]       cfg_index = '0;
  logic [CNT_W-1:0] cfg_data  = '0;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata   = '0;
  logic             s_tuser   = CMD_START;
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tlast;

  int   fail_count;
  int   pending;
  logic busy_now;

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int beats        = 0;
  int ops          = 0;
  int settings     = 0;
  int src_pcts[3]  = '{19, 52, 0};
  int snk_pcts[3]  = '{52, 19, 0};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  jtag_tap_shift_sequencer_core DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  jtss_tick_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .fail_count(fail_count),
    .pending   (pending),
    .busy_now  (busy_now)
  );

  // receiver back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // hard stop
  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [IN_W-1:0] pack_beat(input logic [2:0] op, input logic [31:0] val,
                                                input logic [5:0] len, input logic tdo);
    return {6'd0, tdo, len, val, op};
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(input logic kind, input logic [IN_W-1:0] data);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    beats++;
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_beat(CMD_TICK, pack_beat(3'($urandom_range(0, 7)), $urandom,
                                  6'($urandom_range(0, 63)), 1'($urandom_range(0, 1))));
  endtask

  task automatic send_stray_start(input logic [2:0] op);
    send_beat(CMD_START, pack_beat(op, $urandom, 6'($urandom_range(0, 63)),
                                   1'($urandom_range(0, 1))));
  endtask

  // start one operation and tick it until the model says it is done
  task automatic run_op(input logic [2:0] op, input logic [31:0] val, input logic [5:0] len,
                        input bit meddle);
    send_beat(CMD_START, pack_beat(op, val, len, 1'($urandom_range(0, 1))));
    ops++;
    if (meddle) send_stray_start(3'($urandom_range(0, 7)));
    while (busy_now) begin
      if ($urandom_range(0, 99) < 3) send_stray_start(3'($urandom_range(0, 7)));
      else send_tick();
    end
  endtask

  // wait for the block to go quiet: no ticks owed, no operation open, pipe flushed
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0 || busy_now) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic program_cfg(input logic [CNT_W-1:0] irl, input logic [CNT_W-1:0] irh,
                             input logic [CNT_W-1:0] irt, input logic [CNT_W-1:0] drh,
                             input logic [CNT_W-1:0] drt);
    logic [CNT_W-1:0] vals [5];
    logic [2:0]       reg_ids [5];
    int               i;
    vals    = '{irl, irh, irt, drh, drt};
    reg_ids = '{CFG_IR_LENGTH, CFG_IR_HEADER, CFG_IR_TRAILER, CFG_DR_HEADER, CFG_DR_TRAILER};
    for (i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_ids[i];
      cfg_data  <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    settings++;
    @(negedge clk);
  endtask

  function automatic logic [CNT_W-1:0] pick_bypass();
    case ($urandom_range(0, 9))
      0:       return CNT_W'(0);
      1:       return CNT_W'(MAX_BYPASS_BITS);
      default: return CNT_W'($urandom_range(0, 4));
    endcase
  endfunction

  // one random step from idle: mostly a full operation, sometimes noise
  task automatic random_op();
    int               r;
    logic [2:0]       op;
    logic [CNT_W-1:0] len;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      send_tick();
    end else if (r < 7) begin
      send_stray_start(OP_UNUSED);
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: op = OP_SHIFT_DR;
        4, 5:       op = OP_SHIFT_IR;
        default:    op = 3'($urandom_range(0, 6));
      endcase
      if ($urandom_range(0, 9) == 0) len = CNT_W'($urandom_range(0, 63));
      else len = CNT_W'($urandom_range(1, 32));
      run_op(op, $urandom, len, $urandom_range(0, 19) == 0);
    end
  endtask

  initial begin
    int               mode, k, target;
    logic [CNT_W-1:0] irl;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: idle ticks, unknown state, targets already reached, length clamps
    src_idle_pct = src_pcts[0];
    snk_idle_pct = snk_pcts[0];
    send_tick();
    send_stray_start(OP_UNUSED);
    send_tick();
    run_op(OP_SEL_DR, 32'h0, 6'd1, 1'b0);
    run_op(OP_SEL_DR, 32'h0, 6'd1, 1'b0);
    run_op(OP_SEL_IR, 32'h0, 6'd1, 1'b0);
    run_op(OP_SHIFT_IR, 32'hFFFF_FFFF, 6'd0, 1'b0);
    run_op(OP_SHIFT_DR, 32'hFFFF_FFFF, 6'd0, 1'b1);
    run_op(OP_SHIFT_DR, 32'hA5A5_5A5A, 6'd32, 1'b0);
    run_op(OP_SHIFT_DR, 32'h0, 6'd63, 1'b0);
    run_op(OP_UPD_IDLE, 32'h0, 6'd1, 1'b0);
    run_op(OP_IDLE, 32'h0, 6'd1, 1'b0);
    run_op(OP_UPD_IDLE, 32'h0, 6'd1, 1'b0);
    run_op(OP_RESET, 32'hFFFF_FFFF, 6'd63, 1'b0);
    run_op(OP_UPD_IDLE, 32'h0, 6'd1, 1'b0);
    run_op(OP_IDLE, 32'h0, 6'd1, 1'b0);

    // directed: widest bypass chains, and IR lengths past both ends
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NO_REG;
    cfg_data  <= CNT_W'($urandom_range(0, 63));
    @(negedge clk);
    program_cfg(6'd32, 6'd63, 6'd63, 6'd63, 6'd63);
    run_op(OP_SHIFT_IR, 32'hFFFF_FFFF, 6'd1, 1'b0);
    run_op(OP_SHIFT_DR, 32'h0000_0001, 6'd32, 1'b0);
    settle();
    program_cfg(6'd0, 6'd1, 6'd0, 6'd0, 6'd1);
    run_op(OP_SHIFT_IR, 32'hFFFF_FFFF, 6'd1, 1'b0);
    run_op(OP_SHIFT_DR, 32'hFFFF_FFFF, 6'd1, 1'b0);
    settle();
    program_cfg(6'd63, 6'd0, 6'd1, 6'd1, 6'd0);
    run_op(OP_SHIFT_IR, 32'h8000_0001, 6'd1, 1'b0);
    run_op(OP_SHIFT_DR, 32'h8000_0000, 6'd33, 1'b0);

    // random: three flow-control modes, several register settings in each
    for (mode = 0; mode < 3; mode++) begin
      src_idle_pct = src_pcts[mode];
      snk_idle_pct = snk_pcts[mode];
      for (k = 0; k < SETTINGS_PER_MODE; k++) begin
        settle();
        case ($urandom_range(0, 9))
          0:       irl = CNT_W'(1);
          1:       irl = CNT_W'(DATA_WIDTH);
          2:       irl = CNT_W'($urandom_range(0, 63));
          default: irl = CNT_W'($urandom_range(1, 12));
        endcase
        program_cfg(irl, pick_bypass(), pick_bypass(), pick_bypass(), pick_bypass());
        target = beats + BEATS_PER_SETTING;
        while (beats < target) random_op();
      end
    end

    settle();
    $display("Run covered %0d input beats in %0d operations over %0d register settings,",
             beats, ops, settings);
    $display("under sender stalls, receiver stalls and free flow.");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: jtag_tap_shift_sequencer_core.f
+incdir+rtl
rtl/jtss_pkg.sv
rtl/jtss_step.sv
rtl/jtag_tap_shift_sequencer_core.sv
rtl/jtss_checker.sv
tb/jtss_tick_checker.sv
tb/tb_jtag_tap_shift_sequencer_core.sv
